### rtl/core/shd_pkg.sv
// Shared types and constants for the subrecord header deframer.
// Used by shd_in_reg, shd_parser, shd_out_reg and subrecord_header_deframer.
package shd_pkg;

  // Parser phases
  localparam logic [2:0] PH_NORMAL = 3'd0;  // reading a plain header
  localparam logic [2:0] PH_MSIZE  = 3'd1;  // reading the marker's 32-bit size
  localparam logic [2:0] PH_EXT    = 3'd2;  // reading the header after a marker
  localparam logic [2:0] PH_BODY   = 3'd3;  // skipping body bytes
  localparam logic [2:0] PH_ERROR  = 3'd4;  // ignoring bytes until record end

  // Result kinds
  localparam logic [1:0] KIND_FOUND     = 2'd0;
  localparam logic [1:0] KIND_TRUNCATED = 2'd1;
  localparam logic [1:0] KIND_BAD_MARK  = 2'd2;

  localparam logic [31:0] MARKER_TAG      = 32'h5858_5858;  // 'XXXX'
  localparam logic [15:0] MARKER_BODY_LEN = 16'd4;
  localparam logic [2:0]  SIG_LEN         = 3'd4;
  localparam logic [2:0]  HDR_LEN         = 3'd6;           // signature + 2-byte size
  localparam logic [2:0]  MSIZE_LEN       = 3'd4;

  localparam int OUT_DATA_W = 96;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  byte_count;
    logic [31:0] tag_shift;
    logic [15:0] size_shift;
    logic [31:0] extended_size;
    logic [31:0] body_remaining;
    logic [31:0] record_offset;
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [31:0] body_size;
    logic [31:0] body_offset;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] body_byte;
    logic       record_last;
  } item_t;

endpackage

### rtl/core/subrecord_header_deframer.sv
// Top level of the subrecord header deframer: input stage, parser, result stage.
// Depends on shd_pkg, shd_in_reg, shd_parser and shd_out_reg.
//
// Feed a record body one byte per word on the in_ stream, in_tlast on the final
// byte. The block takes one byte per clock while out_tready does not stall it,
// and emits a word on the out_ stream for every completed subrecord header
// (kind found), for a header cut off by the record end (kind truncated), and
// for an 'XXXX' marker whose size is not 4 while cfg check_marker is set (kind
// bad marker; bytes are then dropped until the record end). A byte waits in the
// input register, the combinational parser steps on it, and its result word is
// captured in the result register. A stall on out_tready holds the result
// register and reaches in_tready in the same cycle, and an empty input register
// can still take one more byte while a result waits. Write the check_marker
// register only while the block is idle.
module subrecord_header_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // Input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] body_byte
  input  logic        in_tlast,     // record_last
  // Result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,    // [31:0] tag, [63:32] body_size, [95:64] body_offset
  output logic [1:0]  out_tuser,    // [1:0] result_kind
  // Configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data   // check_marker
);

  logic             check_marker_r;
  logic             advance;
  shd_pkg::item_t   item;
  logic             res_valid;
  shd_pkg::result_t res;

  // Marker size checking, on after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_marker_r <= 1'b1;
    end else if (cfg_wr_en) begin
      check_marker_r <= cfg_wr_data;
    end
  end

  shd_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .advance   (advance),
    .item      (item)
  );

  // Step the framing state on a held word only when its result has a place to go.
  shd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .check_marker (check_marker_r),
    .step_en      (item.valid && advance),
    .body_byte    (item.body_byte),
    .record_last  (item.record_last),
    .res_valid    (res_valid),
    .res          (res)
  );

  shd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/core/shd_in_reg.sv
// Input register stage of the subrecord header deframer.
// Depends on shd_pkg for the item type.
module shd_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            advance,
  output shd_pkg::item_t  item
);

  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r;

  // Take a new word whenever the held one moves on this cycle or none is held.
  assign in_tready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  assign item.valid       = valid_r;
  assign item.body_byte   = byte_r;
  assign item.record_last = last_r;

endmodule

### rtl/core/shd_parser.sv
// Framing state and one-byte step logic of the subrecord header deframer.
// Depends on shd_pkg for phase codes, result kinds and the state/result types.
module shd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             check_marker,
  input  logic             step_en,
  input  logic [7:0]       body_byte,
  input  logic             record_last,
  output logic             res_valid,
  output shd_pkg::result_t res
);

  shd_pkg::state_t state_r;
  shd_pkg::state_t state_nxt;
  logic [2:0]      bc_inc;
  logic [31:0]     next_off;
  logic [31:0]     tag_sh;

  always_comb begin
    state_nxt = state_r;
    res_valid = 1'b0;
    res       = '0;
    bc_inc    = state_r.byte_count + 3'd1;
    next_off  = state_r.record_offset + 32'd1;
    tag_sh    = {state_r.tag_shift[23:0], body_byte};

    if (step_en) begin
      case (state_r.phase)
        shd_pkg::PH_NORMAL: begin
          if (state_r.byte_count < shd_pkg::SIG_LEN) begin
            state_nxt.tag_shift = tag_sh;
          end else if (state_r.byte_count == shd_pkg::SIG_LEN) begin
            state_nxt.size_shift[7:0] = body_byte;
          end else begin
            state_nxt.size_shift[15:8] = body_byte;
          end
          state_nxt.byte_count = bc_inc;
          if (bc_inc == shd_pkg::HDR_LEN) begin
            state_nxt.byte_count = '0;
            if (state_nxt.tag_shift == shd_pkg::MARKER_TAG) begin
              if (check_marker && state_nxt.size_shift != shd_pkg::MARKER_BODY_LEN) begin
                res_valid       = 1'b1;
                res.kind        = shd_pkg::KIND_BAD_MARK;
                res.tag         = state_nxt.tag_shift;
                res.body_size   = {16'd0, state_nxt.size_shift};
                res.body_offset = next_off;
                state_nxt.phase = shd_pkg::PH_ERROR;
              end else begin
                state_nxt.extended_size = '0;
                state_nxt.phase         = shd_pkg::PH_MSIZE;
              end
            end else begin
              res_valid                = 1'b1;
              res.kind                 = shd_pkg::KIND_FOUND;
              res.tag                  = state_nxt.tag_shift;
              res.body_size            = {16'd0, state_nxt.size_shift};
              res.body_offset          = next_off;
              state_nxt.body_remaining = {16'd0, state_nxt.size_shift};
              state_nxt.phase          = (state_nxt.size_shift != '0) ?
                                         shd_pkg::PH_BODY : shd_pkg::PH_NORMAL;
            end
            state_nxt.tag_shift  = '0;
            state_nxt.size_shift = '0;
          end
        end
        shd_pkg::PH_MSIZE: begin
          // Little-endian 32-bit size, one byte lane per count.
          state_nxt.extended_size[{state_r.byte_count[1:0], 3'b000} +: 8] = body_byte;
          state_nxt.byte_count = bc_inc;
          if (bc_inc == shd_pkg::MSIZE_LEN) begin
            state_nxt.byte_count = '0;
            state_nxt.phase      = shd_pkg::PH_EXT;
          end
        end
        shd_pkg::PH_EXT: begin
          // Own 2-byte size is dropped; the marker's size takes its place.
          if (state_r.byte_count < shd_pkg::SIG_LEN) begin
            state_nxt.tag_shift = tag_sh;
          end
          state_nxt.byte_count = bc_inc;
          if (bc_inc == shd_pkg::HDR_LEN) begin
            state_nxt.byte_count     = '0;
            res_valid                = 1'b1;
            res.kind                 = shd_pkg::KIND_FOUND;
            res.tag                  = state_nxt.tag_shift;
            res.body_size            = state_r.extended_size;
            res.body_offset          = next_off;
            state_nxt.body_remaining = state_r.extended_size;
            state_nxt.phase          = (state_r.extended_size != '0) ?
                                       shd_pkg::PH_BODY : shd_pkg::PH_NORMAL;
            state_nxt.tag_shift      = '0;
          end
        end
        shd_pkg::PH_BODY: begin
          state_nxt.body_remaining = state_r.body_remaining - 32'd1;
          if (state_nxt.body_remaining == '0) begin
            state_nxt.phase = shd_pkg::PH_NORMAL;
          end
        end
        default: begin
          // Error phase and unused codes: drop the byte.
        end
      endcase

      state_nxt.record_offset = next_off;

      if (record_last) begin
        if (!res_valid &&
            (state_nxt.phase == shd_pkg::PH_MSIZE ||
             state_nxt.phase == shd_pkg::PH_EXT ||
             (state_nxt.phase == shd_pkg::PH_NORMAL && state_nxt.byte_count != '0))) begin
          res_valid       = 1'b1;
          res.kind        = shd_pkg::KIND_TRUNCATED;
          res.tag         = state_nxt.tag_shift;
          res.body_size   = '0;
          res.body_offset = next_off;
        end
        state_nxt       = '0;
        state_nxt.phase = shd_pkg::PH_NORMAL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= '0;
      state_r.phase <= shd_pkg::PH_NORMAL;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/shd_out_reg.sv
// Result register stage of the subrecord header deframer.
// Depends on shd_pkg for the result type and the output data width.
module shd_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          res_valid,
  input  shd_pkg::result_t              res,
  output logic                          advance,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [shd_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                    out_tuser
);

  logic             valid_r;
  shd_pkg::result_t res_r;

  // The slot is free for a new result when empty or being emptied now.
  assign advance = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.body_offset, res_r.body_size, res_r.tag};
  assign out_tuser  = res_r.kind;

endmodule
